// ===== rtl/bakery_ticket_lock_arbiter_unit_macros.svh =====
// Assertion macros shared by the lock arbiter.
// Both macros sample on the rising edge of clock and are disabled during reset.
`ifndef BAKERY_TICKET_LOCK_ARBITER_UNIT_MACROS_SVH
`define BAKERY_TICKET_LOCK_ARBITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTLA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/btla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btla_pkg;

   // Sizing of the ticket file.
   localparam int THREADS = 16;
   localparam int TICKET_BITS = 16;
   localparam int IDX_BITS = $clog2(THREADS);
   localparam int CNT_BITS = $clog2(THREADS + 1);

   // Fixed widths of the item fields.
   localparam int TID_BITS = 4;
   localparam int TICKET_FIELD_BITS = 16;

   typedef logic [TICKET_BITS-1:0] ticket_type;
   typedef logic [IDX_BITS-1:0] index_type;

   localparam ticket_type TICKET_TOP = '1;

   // Command codes.
   localparam logic CMD_ACQUIRE = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      STATUS_GRANTED  = 3'd0,
      STATUS_QUEUED   = 3'd1,
      STATUS_HANDED   = 3'd2,
      STATUS_FREED    = 3'd3,
      STATUS_BAD      = 3'd4,
      STATUS_OVERFLOW = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_RESULT
   } state_type;

   // Running result of the scan, handed from cell to cell.
   typedef struct packed {
      ticket_type max_value;
      logic       found;
      ticket_type best_value;
      index_type  best_index;
   } scan_carry_type;

   // Write command for one ticket cell.
   typedef struct packed {
      logic       wr_en;
      ticket_type wr_value;
   } cell_write_type;

   // Low bits of a ticket as returned in an item.
   function automatic logic [TICKET_FIELD_BITS-1:0] ticket_field(input ticket_type t);
      logic [31:0] wide;
      wide = 32'(t);
      return wide[TICKET_FIELD_BITS-1:0];
   endfunction

   // Low bits of a thread index as returned in an item.
   function automatic logic [TID_BITS-1:0] index_field(input index_type idx);
      logic [31:0] wide;
      wide = 32'(idx);
      return wide[TID_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/btla_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one acquire or release item per handshake.
interface btla_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic [btla_pkg::TID_BITS-1:0]    thread_id;

   modport source (output valid, output command, output thread_id, input ready);
   modport sink (input valid, input command, input thread_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/btla_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Response channel: one result item per request item.
interface btla_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [2:0]                               status;
   logic                                     grant_valid;
   logic [btla_pkg::TID_BITS-1:0]            grant_thread;
   logic [btla_pkg::TICKET_FIELD_BITS-1:0]   ticket_value;

   modport source (output valid, output status, output grant_valid, output grant_thread,
                   output ticket_value, input ready);
   modport sink (input valid, input status, input grant_valid, input grant_thread,
                 input ticket_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/btla_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One ticket slot. It folds its ticket into the running maximum and minimum
// and passes the registered result on to the next cell every cycle.
module btla_cell (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire btla_pkg::index_type      cell_index,
   input  wire btla_pkg::cell_write_type write,
   input  wire btla_pkg::scan_carry_type scan_prev,
   output btla_pkg::scan_carry_type      scan_next,
   output logic                          occupied
);

   btla_pkg::ticket_type     ticket_ff;
   btla_pkg::ticket_type     ticket_in;
   btla_pkg::scan_carry_type scan_ff;
   btla_pkg::scan_carry_type scan_in;

   // Ticket storage; zero means no request outstanding.
   always_comb begin
      ticket_in = ticket_ff;
      if (write.wr_en) begin
         ticket_in = write.wr_value;
      end
   end

   // Fold this ticket into the running scan result. A strict compare keeps
   // the lower thread on a tie.
   always_comb begin
      scan_in = scan_prev;
      if (ticket_ff > scan_prev.max_value) begin
         scan_in.max_value = ticket_ff;
      end
      if ((ticket_ff != '0) && (!scan_prev.found || (ticket_ff < scan_prev.best_value))) begin
         scan_in.found      = 1'b1;
         scan_in.best_value = ticket_ff;
         scan_in.best_index = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticket_ff <= '0;
      end else begin
         ticket_ff <= ticket_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   assign scan_next = scan_ff;
   assign occupied  = (ticket_ff != '0);

endmodule

`default_nettype wire

// ===== rtl/bakery_ticket_lock_arbiter_unit.sv =====
// A valid request item is scanned through the chain of ticket cells, one cell per cycle,
// and its result is then loaded; a bad request gives its result in the next cycle.
// The block holds one item at a time: the next request is taken only once the result
// has been taken and the block is back in idle.
// Reset is synchronous and active high: all tickets clear and the lock is free.
`timescale 1ns / 1ps
`default_nettype none

`include "bakery_ticket_lock_arbiter_unit_macros.svh"

module bakery_ticket_lock_arbiter_unit (
   input wire logic clock,
   input wire logic reset,
   btla_req_if.sink   req,
   btla_rsp_if.source rsp
);

   localparam btla_pkg::scan_carry_type SCAN_START = '0;

   btla_pkg::state_type state_ff;
   btla_pkg::state_type state_in;

   logic [btla_pkg::CNT_BITS-1:0] count_ff;
   logic [btla_pkg::CNT_BITS-1:0] count_in;
   logic                          op_command_ff;
   logic                          op_command_in;
   btla_pkg::index_type           op_index_ff;
   btla_pkg::index_type           op_index_in;
   logic                          holder_valid_ff;
   logic                          holder_valid_in;
   btla_pkg::index_type           holder_thread_ff;
   btla_pkg::index_type           holder_thread_in;

   btla_pkg::status_type                     status_ff;
   btla_pkg::status_type                     status_in;
   logic                                     grant_valid_ff;
   logic                                     grant_valid_in;
   logic [btla_pkg::TID_BITS-1:0]            grant_thread_ff;
   logic [btla_pkg::TID_BITS-1:0]            grant_thread_in;
   logic [btla_pkg::TICKET_FIELD_BITS-1:0]   ticket_value_ff;
   logic [btla_pkg::TICKET_FIELD_BITS-1:0]   ticket_value_in;

   btla_pkg::scan_carry_type scan_chain [btla_pkg::THREADS+1];
   btla_pkg::scan_carry_type scan_final;
   logic [btla_pkg::THREADS-1:0] occupied_vec;

   logic                 write_en;
   btla_pkg::index_type  write_index;
   btla_pkg::ticket_type write_value;

   logic                req_accept;
   logic                req_in_range;
   btla_pkg::index_type req_index;
   logic                req_bad;
   logic                scan_done;
   btla_pkg::ticket_type issued;

   // Chain of ticket cells; the scan enters at cell zero with an empty result.
   assign scan_chain[0] = SCAN_START;

   for (genvar i = 0; i < btla_pkg::THREADS; i++) begin : g_cell
      btla_pkg::cell_write_type cell_write;

      assign cell_write.wr_en    = write_en && (write_index == btla_pkg::index_type'(i));
      assign cell_write.wr_value = write_value;

      btla_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (btla_pkg::index_type'(i)),
         .write      (cell_write),
         .scan_prev  (scan_chain[i]),
         .scan_next  (scan_chain[i+1]),
         .occupied   (occupied_vec[i])
      );
   end

   assign scan_final = scan_chain[btla_pkg::THREADS];

   // Request decode and validity checks.
   assign req_accept   = req.valid && req.ready;
   assign req_in_range = (int'(req.thread_id) < btla_pkg::THREADS);
   assign req_index    = btla_pkg::index_type'(req.thread_id);
   assign req_bad      = !req_in_range
                      || ((req.command == btla_pkg::CMD_ACQUIRE) && occupied_vec[req_index])
                      || ((req.command == btla_pkg::CMD_RELEASE)
                          && (!holder_valid_ff || (holder_thread_ff != req_index)));
   assign scan_done    = (state_ff == btla_pkg::STATE_SCAN) && (count_ff == '0);
   assign issued       = scan_final.max_value + btla_pkg::ticket_type'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btla_pkg::STATE_IDLE: begin
            if (req_accept) begin
               state_in = req_bad ? btla_pkg::STATE_RESULT : btla_pkg::STATE_SCAN;
            end
         end
         btla_pkg::STATE_SCAN: begin
            if (count_ff == '0) begin
               state_in = btla_pkg::STATE_RESULT;
            end
         end
         btla_pkg::STATE_RESULT: begin
            if (rsp.ready) begin
               state_in = btla_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = btla_pkg::STATE_IDLE;
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req.ready = (state_ff == btla_pkg::STATE_IDLE);
      rsp.valid = (state_ff == btla_pkg::STATE_RESULT);
   end

   assign rsp.status       = status_ff;
   assign rsp.grant_valid  = grant_valid_ff;
   assign rsp.grant_thread = grant_thread_ff;
   assign rsp.ticket_value = ticket_value_ff;

   // Operation datapath: ticket writes, lock ownership and the result item.
   always_comb begin
      count_in         = count_ff;
      op_command_in    = op_command_ff;
      op_index_in      = op_index_ff;
      holder_valid_in  = holder_valid_ff;
      holder_thread_in = holder_thread_ff;
      status_in        = status_ff;
      grant_valid_in   = grant_valid_ff;
      grant_thread_in  = grant_thread_ff;
      ticket_value_in  = ticket_value_ff;
      write_en         = 1'b0;
      write_index      = op_index_ff;
      write_value      = '0;

      if ((state_ff == btla_pkg::STATE_IDLE) && req_accept) begin
         op_command_in = req.command;
         op_index_in   = req_index;
         count_in      = btla_pkg::CNT_BITS'(btla_pkg::THREADS);
         if (req_bad) begin
            status_in       = btla_pkg::STATUS_BAD;
            grant_valid_in  = 1'b0;
            grant_thread_in = '0;
            ticket_value_in = '0;
         end else if (req.command == btla_pkg::CMD_RELEASE) begin
            // The holder's ticket clears before the scan for the next holder.
            write_en    = 1'b1;
            write_index = req_index;
            write_value = '0;
         end
      end

      if ((state_ff == btla_pkg::STATE_SCAN) && (count_ff != '0)) begin
         count_in = count_ff - btla_pkg::CNT_BITS'(1);
      end

      if (scan_done) begin
         grant_valid_in  = 1'b0;
         grant_thread_in = '0;
         ticket_value_in = '0;
         if (op_command_ff == btla_pkg::CMD_ACQUIRE) begin
            if (scan_final.max_value == btla_pkg::TICKET_TOP) begin
               status_in = btla_pkg::STATUS_OVERFLOW;
            end else begin
               write_en        = 1'b1;
               write_index     = op_index_ff;
               write_value     = issued;
               ticket_value_in = btla_pkg::ticket_field(issued);
               if (!holder_valid_ff) begin
                  holder_valid_in  = 1'b1;
                  holder_thread_in = op_index_ff;
                  status_in        = btla_pkg::STATUS_GRANTED;
                  grant_valid_in   = 1'b1;
                  grant_thread_in  = btla_pkg::index_field(op_index_ff);
               end else begin
                  status_in = btla_pkg::STATUS_QUEUED;
               end
            end
         end else begin
            if (scan_final.found) begin
               holder_thread_in = scan_final.best_index;
               status_in        = btla_pkg::STATUS_HANDED;
               grant_valid_in   = 1'b1;
               grant_thread_in  = btla_pkg::index_field(scan_final.best_index);
               ticket_value_in  = btla_pkg::ticket_field(scan_final.best_value);
            end else begin
               holder_valid_in  = 1'b0;
               holder_thread_in = '0;
               status_in        = btla_pkg::STATUS_FREED;
            end
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= btla_pkg::STATE_IDLE;
         holder_valid_ff  <= 1'b0;
         holder_thread_ff <= '0;
      end else begin
         state_ff         <= state_in;
         holder_valid_ff  <= holder_valid_in;
         holder_thread_ff <= holder_thread_in;
      end
   end

   // Operation and result registers.
   always_ff @(posedge clock) begin
      count_ff        <= count_in;
      op_command_ff   <= op_command_in;
      op_index_ff     <= op_index_in;
      status_ff       <= status_in;
      grant_valid_ff  <= grant_valid_in;
      grant_thread_ff <= grant_thread_in;
      ticket_value_ff <= ticket_value_in;
   end

   // A free lock leaves no ticket outstanding between items.
   `BTLA_ASSERT_SAME(a_free_lock_no_tickets,
      (state_ff == btla_pkg::STATE_IDLE) && !holder_valid_ff,
      occupied_vec == '0, "lock free while tickets remain")
   // A grant is reported only with a granting status.
   `BTLA_ASSERT_SAME(a_grant_status, rsp.valid && rsp.grant_valid,
      (rsp.status == btla_pkg::STATUS_GRANTED) || (rsp.status == btla_pkg::STATUS_HANDED),
      "grant with non-granting status")
   // The lock holder always owns an outstanding ticket between items.
   `BTLA_ASSERT_SAME(a_holder_has_ticket,
      (state_ff == btla_pkg::STATE_IDLE) && holder_valid_ff,
      occupied_vec[holder_thread_ff], "holder without a ticket")
   // Only one item is in hand at a time.
   `BTLA_ASSERT_NEXT(a_one_item, req_accept, !req.ready, "request taken while busy")

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = btla_pkg::THREADS + 4;
   localparam int PHASE_ITEMS  = 570;

   // One result item as the block should return it.
   typedef struct packed {
      btla_pkg::status_type                   status;
      logic                                   grant_valid;
      logic [btla_pkg::TID_BITS-1:0]          grant_thread;
      logic [btla_pkg::TICKET_FIELD_BITS-1:0] ticket_value;
   } lock_result_type;

   // Tracks the ticket file and the lock holder, and keeps the results still owed.
   class lock_grant_tracker_type;
      btla_pkg::ticket_type tickets [btla_pkg::THREADS];
      bit                   holder_valid;
      btla_pkg::index_type  holder;
      lock_result_type      pending_grants [$];
      int                   requests;
      int                   responses;
      int                   mismatches;
      int                   status_count [6];
      btla_pkg::ticket_type top_issued;

      function new();
         foreach (tickets[i]) tickets[i] = '0;
         foreach (status_count[i]) status_count[i] = 0;
         holder_valid = 1'b0;
         holder       = '0;
         requests     = 0;
         responses    = 0;
         mismatches   = 0;
         top_issued   = '0;
      endfunction

      function int outstanding();
         int n;
         n = 0;
         foreach (tickets[i]) if (tickets[i] != '0) n++;
         return n;
      endfunction

      function btla_pkg::ticket_type max_ticket();
         btla_pkg::ticket_type peak;
         peak = '0;
         foreach (tickets[i]) if (tickets[i] > peak) peak = tickets[i];
         return peak;
      endfunction

      // Applies one accepted item to the lock state and queues its result.
      function void note_request(logic cmd, logic [btla_pkg::TID_BITS-1:0] tid);
         lock_result_type      res;
         btla_pkg::index_type  idx;
         btla_pkg::ticket_type issued;
         btla_pkg::ticket_type best_value;
         btla_pkg::index_type  best;
         bit                   found;
         res.status       = btla_pkg::STATUS_BAD;
         res.grant_valid  = 1'b0;
         res.grant_thread = '0;
         res.ticket_value = '0;
         idx = btla_pkg::index_type'(tid);
         requests++;
         if (int'(tid) >= btla_pkg::THREADS) begin
            // An unknown thread leaves everything untouched.
         end else if (cmd == btla_pkg::CMD_ACQUIRE) begin
            if (tickets[idx] != '0) begin
               // A thread may hold only one ticket at a time.
            end else if (max_ticket() == btla_pkg::TICKET_TOP) begin
               res.status = btla_pkg::STATUS_OVERFLOW;
            end else begin
               issued = max_ticket() + 1'b1;
               tickets[idx] = issued;
               if (issued > top_issued) top_issued = issued;
               res.ticket_value = issued;
               if (!holder_valid) begin
                  holder_valid     = 1'b1;
                  holder           = idx;
                  res.status       = btla_pkg::STATUS_GRANTED;
                  res.grant_valid  = 1'b1;
                  res.grant_thread = tid;
               end else begin
                  res.status = btla_pkg::STATUS_QUEUED;
               end
            end
         end else if (holder_valid && holder == idx) begin
            // The holder lets go; the smallest ticket wins, the lower thread on a tie.
            tickets[idx] = '0;
            found      = 1'b0;
            best       = '0;
            best_value = '0;
            for (int i = 0; i < btla_pkg::THREADS; i++) begin
               if (tickets[i] != '0 && (!found || tickets[i] < best_value)) begin
                  found      = 1'b1;
                  best       = btla_pkg::index_type'(i);
                  best_value = tickets[i];
               end
            end
            if (found) begin
               holder           = best;
               res.status       = btla_pkg::STATUS_HANDED;
               res.grant_valid  = 1'b1;
               res.grant_thread = best;
               res.ticket_value = best_value;
            end else begin
               holder_valid = 1'b0;
               holder       = '0;
               res.status   = btla_pkg::STATUS_FREED;
            end
         end
         pending_grants.push_back(res);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t ns: %s differs, expected %0d, got %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      // Compares one accepted result item with the oldest one owed.
      function void check_response(lock_result_type got);
         lock_result_type want;
         responses++;
         if (pending_grants.size() == 0) begin
            $display("%0t ns: result item with none expected, status %0d, thread %0d, ticket %0d",
                     $time, got.status, got.grant_thread, got.ticket_value);
            mismatches++;
            return;
         end
         want = pending_grants.pop_front();
         status_count[int'(want.status)]++;
         compare_field("status", want.status, got.status);
         compare_field("grant_valid", want.grant_valid, got.grant_valid);
         compare_field("grant_thread", want.grant_thread, got.grant_thread);
         compare_field("ticket_value", want.ticket_value, got.ticket_value);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   btla_req_if req_ch ();
   btla_rsp_if rsp_ch ();

   bakery_ticket_lock_arbiter_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   lock_grant_tracker_type tracker;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_request = 1'b0;
   int quiet_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // Both channels are sampled mid-cycle, where nothing changes until the next edge.
   always @(negedge clock) begin
      lock_result_type got;
      if (!reset) begin
         quiet_cycles++;
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_request(req_ch.command, req_ch.thread_id);
            quiet_cycles = 0;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.status       = btla_pkg::status_type'(rsp_ch.status);
            got.grant_valid  = rsp_ch.grant_valid;
            got.grant_thread = rsp_ch.grant_thread;
            got.ticket_value = rsp_ch.ticket_value;
            tracker.check_response(got);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles", $time, QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Offers one item after a random gap and returns at the edge that accepts it.
   task automatic send_item(input logic cmd, input logic [btla_pkg::TID_BITS-1:0] tid);
      bit fired;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid     <= 1'b0;
         req_ch.command   <= 1'($urandom);
         req_ch.thread_id <= btla_pkg::TID_BITS'($urandom);
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.thread_id <= tid;
      do begin
         @(negedge clock);
         fired = req_ch.ready;
         @(posedge clock);
      end while (!fired);
   endtask

   // Stops offering and waits until every owed result item has arrived.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (tracker.pending_grants.size() != 0) @(posedge clock);
   endtask

   // Mostly orderly lock traffic, with some arbitrary items mixed in.
   task automatic send_random_item();
      logic [btla_pkg::TID_BITS-1:0] tid;
      if ($urandom_range(99) < 12) begin
         send_item(1'($urandom), btla_pkg::TID_BITS'($urandom));
      end else if (tracker.outstanding() == btla_pkg::THREADS ||
                   (tracker.holder_valid &&
                    $urandom_range(99) < tracker.outstanding() * 7)) begin
         send_item(btla_pkg::CMD_RELEASE, tracker.holder);
      end else begin
         do tid = btla_pkg::TID_BITS'($urandom); while (tracker.tickets[tid] != '0);
         send_item(btla_pkg::CMD_ACQUIRE, tid);
      end
   endtask

   task automatic run_random_phase(input int items);
      repeat (items) send_random_item();
   endtask

   initial begin
      tracker = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= btla_pkg::CMD_ACQUIRE;
      req_ch.thread_id <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Sender rarely idle, receiver mostly stalled.
      tx_idle_pct = 16;
      rx_idle_pct = 79;

      // Directed: release of a free lock, double acquire, release by a non-holder,
      // hand-over in ticket order and a lock that becomes free again.
      send_item(btla_pkg::CMD_RELEASE, 4'd0);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd0);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd0);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd15);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd7);
      send_item(btla_pkg::CMD_RELEASE, 4'd15);
      send_item(btla_pkg::CMD_RELEASE, 4'd0);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd0);
      send_item(btla_pkg::CMD_RELEASE, 4'd15);
      send_item(btla_pkg::CMD_RELEASE, 4'd7);
      send_item(btla_pkg::CMD_RELEASE, 4'd0);
      send_item(btla_pkg::CMD_RELEASE, 4'd0);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd5);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd14);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd1);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd8);
      send_item(btla_pkg::CMD_RELEASE, 4'd8);
      send_item(btla_pkg::CMD_RELEASE, 4'd5);
      send_item(btla_pkg::CMD_RELEASE, 4'd14);
      send_item(btla_pkg::CMD_RELEASE, 4'd1);
      send_item(btla_pkg::CMD_RELEASE, 4'd8);

      run_random_phase(PHASE_ITEMS);
      wait_drained();

      // Sender mostly idle, receiver rarely stalled.
      tx_idle_pct = 79;
      rx_idle_pct = 16;
      run_random_phase(PHASE_ITEMS);
      wait_drained();

      // No idling. The receiver holds off for a long stretch so that the input backs up,
      // then the sender pauses until the block has caught up.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_request = 1'b1;
      run_random_phase(12);
      wait_drained();
      run_random_phase(PHASE_ITEMS - 12);
      wait_drained();

      // Hand the lock round until it is free, then take and drop it once more.
      while (tracker.holder_valid) send_item(btla_pkg::CMD_RELEASE, tracker.holder);
      send_item(btla_pkg::CMD_ACQUIRE, 4'd6);
      send_item(btla_pkg::CMD_RELEASE, 4'd6);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.pending_grants.size() != 0) begin
         $display("%0t ns: %0d result items never arrived", $time,
                  tracker.pending_grants.size());
      end
      $display("Run covered %0d request items and %0d result items, tickets up to %0d.",
               tracker.requests, tracker.responses, tracker.top_issued);
      $display("Granted %0d, queued %0d, handed over %0d, freed %0d, bad %0d, overflow %0d.",
               tracker.status_count[btla_pkg::STATUS_GRANTED],
               tracker.status_count[btla_pkg::STATUS_QUEUED],
               tracker.status_count[btla_pkg::STATUS_HANDED],
               tracker.status_count[btla_pkg::STATUS_FREED],
               tracker.status_count[btla_pkg::STATUS_BAD],
               tracker.status_count[btla_pkg::STATUS_OVERFLOW]);
      if (tracker.mismatches == 0 && tracker.pending_grants.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/btla_pkg.sv
rtl/btla_req_if.sv
rtl/btla_rsp_if.sv
rtl/btla_cell.sv
rtl/bakery_ticket_lock_arbiter_unit.sv
verif/testbench.sv
